@@ rtl/core/costmap_front_window_scan_top_defines.svh @@
// Assertion macros shared by the front window scan RTL.
`ifndef COSTMAP_FRONT_WINDOW_SCAN_TOP_DEFINES_SVH
`define COSTMAP_FRONT_WINDOW_SCAN_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define CFWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("front window scan check failed");

// The antecedent implies the consequent in the next cycle.
`define CFWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("front window scan check failed");

`endif

@@ rtl/core/cfws_pkg.sv @@
`default_nettype none
package cfws_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Numerator of the heading division: |term| * 2^14 plus half the norm.
    localparam int DIV_NUM_W = 46;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_MAX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COST_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd5;

    localparam logic [31:0] FRONT_MIN_X_RST    = 32'd0;
    localparam logic [31:0] FRONT_MAX_X_RST    = 32'd98304;
    localparam logic [30:0] HALF_WIDTH_RST     = 31'd26214;
    localparam logic [7:0]  COST_THRESHOLD_RST = 8'd253;
    localparam logic [30:0] CELL_SIZE_RST      = 31'd3277;
    localparam logic [8:0]  MAP_WIDTH_RST      = 9'd128;

    localparam logic [14:0] UNIT_Q14    = 15'd16384;
    localparam logic [16:0] COUNT_LIMIT = 17'd65536;

    typedef struct packed {
        logic load;
        logic hdg;
        logic sq_s;
        logic sq_c;
        logic sqrt_start;
        logic heading_unit;
        logic div_start;
        logic div_sel_sin;
        logic store_cos;
        logic store_sin;
        logic cell_d;
        logic cell_m;
        logic cell_t;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic root_zero;
        logic last_item;
        logic out_valid;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/costmap_front_window_scan_top.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata, s_tuser (kind), s_tlast (last_cell)
// m_        out        m_tvalid / m_tready  m_tdata
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A cost cell item passes in turn through acceptance, offset, rotation products and
// the window test. A pose item runs the 32-step square root and, if the root is nonzero,
// two 46-step divisions that share one divider. Reset is synchronous on aresetn and
// restores the register defaults and zero cosine and sine terms. A stalled output holds
// the result in its register; new items are still taken until a further result is due.
`default_nettype none
`include "costmap_front_window_scan_top_defines.svh"
module costmap_front_window_scan_top #(
    parameter int MAX_WIDTH  = cfws_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cfws_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // quat_x, quat_y, quat_z, quat_w, robot_x, robot_y, map_origin_x,
    // map_origin_y, cell_cost
    input  logic [cfws_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // blocked, map_unavailable, occupied_count, sample_count, peak_cost, zero pad
    output logic [cfws_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfws_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cfws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    cfws_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // Every accepted item leaves the sequencer busy, so s_tready drops once it is taken.
    `CFWS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // An empty map always reports blocked.
    `CFWS_ASSERT_NOW(a_unavail_blocked, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[0])
    // An empty map carries no counts.
    `CFWS_ASSERT_NOW(a_unavail_zero, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[43:2] == 42'd0)
    // Occupied cells are a subset of the sampled cells.
    `CFWS_ASSERT_NOW(a_occ_le_samp, aclk, aresetn, m_tvalid, m_tdata[18:2] <= m_tdata[35:19])

endmodule
`default_nettype wire

@@ rtl/core/cfws_isqrt.sv @@
`default_nettype none
module cfws_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_sub;
    logic        fits;

    // One result bit per cycle, two radicand bits shifted in each step.
    assign rem_sh  = {rem_reg, rad_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'd32;
            end else if (cnt_reg != 6'd0) begin
                rad_reg  <= {rad_reg[61:0], 2'b00};
                rem_reg  <= fits ? rem_sub[33:0] : rem_sh[33:0];
                root_reg <= {root_reg[30:0], fits};
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

@@ rtl/core/cfws_div.sv @@
`default_nettype none
module cfws_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cfws_pkg::DIV_NUM_W-1:0] numerator,
    input  logic [31:0]                   divisor,
    output logic                          done,
    output logic [cfws_pkg::DIV_NUM_W-1:0] quotient
);
    import cfws_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg;
    logic [31:0]          den_reg;
    logic [31:0]          rem_reg;
    logic [5:0]           cnt_reg;
    logic                 done_reg;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 fits;

    // Restoring division; quotient bits replace the numerator bits as they go.
    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= numerator;
                den_reg <= divisor;
                rem_reg <= '0;
                cnt_reg <= 6'(DIV_NUM_W);
            end else if (cnt_reg != 6'd0) begin
                num_reg  <= {num_reg[DIV_NUM_W-2:0], fits};
                rem_reg  <= fits ? rem_sub[31:0] : rem_sh[31:0];
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
`default_nettype wire

@@ rtl/core/cfws_dp.sv @@
`default_nettype none
module cfws_dp #(
    parameter int MAX_WIDTH  = cfws_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cfws_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [cfws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfws_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [cfws_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    input  logic                           m_tready,
    input  cfws_pkg::cmd_t                 cmd,
    output cfws_pkg::status_t              status,
    output logic                           m_tvalid,
    output logic [cfws_pkg::M_DATA_W-1:0]   m_tdata
);
    import cfws_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IW   = (CW > RW) ? CW : RW;
    localparam int DW   = IW + 35;
    localparam int PW   = DW + 16;
    localparam int CMPW = (CW + 1 > 9) ? CW + 1 : 9;

    // Configuration registers
    logic signed [31:0] front_min_x_reg;
    logic signed [31:0] front_max_x_reg;
    logic [30:0]        half_width_reg;
    logic [7:0]         cost_threshold_reg;
    logic [30:0]        cell_size_reg;
    logic [8:0]         map_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_min_x_reg    <= FRONT_MIN_X_RST;
            front_max_x_reg    <= FRONT_MAX_X_RST;
            half_width_reg     <= HALF_WIDTH_RST;
            cost_threshold_reg <= COST_THRESHOLD_RST;
            cell_size_reg      <= CELL_SIZE_RST;
            map_width_reg      <= MAP_WIDTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRONT_MIN_X:    front_min_x_reg    <= cfg_data;
                REG_FRONT_MAX_X:    front_max_x_reg    <= cfg_data;
                REG_HALF_WIDTH:     half_width_reg     <= cfg_data[30:0];
                REG_COST_THRESHOLD: cost_threshold_reg <= cfg_data[7:0];
                REG_CELL_SIZE:      cell_size_reg      <= cfg_data[30:0];
                REG_MAP_WIDTH:      map_width_reg      <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Item registers
    logic               kind_reg;
    logic               last_reg;
    logic [7:0]         cost_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [31:0]        pose_x_reg, pose_y_reg, origin_x_reg, origin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= 1'b0;
            last_reg     <= 1'b0;
            pose_x_reg   <= '0;
            pose_y_reg   <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cmd.load) begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
            if (!s_tuser) begin
                pose_x_reg   <= s_tdata[95:64];
                pose_y_reg   <= s_tdata[127:96];
                origin_x_reg <= s_tdata[159:128];
                origin_y_reg <= s_tdata[191:160];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cost_reg <= s_tdata[199:192];
            qx_reg   <= s_tdata[15:0];
            qy_reg   <= s_tdata[31:16];
            qz_reg   <= s_tdata[47:32];
            qw_reg   <= s_tdata[63:48];
        end
    end

    // Heading: S/2 and C/2 in units of 2^-30, then the norm and two divisions.
    logic signed [33:0] sh_next, ch_next, sh_reg, ch_reg, sh_neg, ch_neg;
    logic [31:0]        abs_s, abs_c, abs_sel;
    logic [63:0]        sq_prod, acc_reg;
    logic [31:0]        root;
    logic               sqrt_done;
    logic [DIV_NUM_W-1:0] div_num, quotient;
    logic               div_done;
    logic [14:0]        mag;
    logic signed [15:0] term_pos;
    logic signed [15:0] cos_reg, sin_reg;

    assign sh_next = qw_reg * qz_reg + qx_reg * qy_reg;
    assign ch_next = 34'sd536870912 - (qy_reg * qy_reg + qz_reg * qz_reg);
    assign sh_neg  = -sh_reg;
    assign ch_neg  = -ch_reg;
    assign abs_s   = sh_reg[33] ? sh_neg[31:0] : sh_reg[31:0];
    assign abs_c   = ch_reg[33] ? ch_neg[31:0] : ch_reg[31:0];
    assign abs_sel = cmd.sq_c ? abs_c : abs_s;
    assign sq_prod = abs_sel * abs_sel;

    always_ff @(posedge aclk) begin
        if (cmd.hdg) begin
            sh_reg <= sh_next;
            ch_reg <= ch_next;
        end
        if (cmd.sq_s) begin
            acc_reg <= sq_prod;
        end else if (cmd.sq_c) begin
            acc_reg <= acc_reg + sq_prod;
        end
    end

    cfws_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    assign div_num = {(cmd.div_sel_sin ? abs_s : abs_c), 14'b0}
                   + DIV_NUM_W'(root[31:1]);

    cfws_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .numerator (div_num),
        .divisor   (root),
        .done      (div_done),
        .quotient  (quotient)
    );

    assign mag      = (quotient > DIV_NUM_W'(UNIT_Q14)) ? UNIT_Q14 : quotient[14:0];
    assign term_pos = {1'b0, mag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= '0;
            sin_reg <= '0;
        end else if (cmd.heading_unit) begin
            cos_reg <= {1'b0, UNIT_Q14};
            sin_reg <= '0;
        end else if (cmd.store_cos) begin
            cos_reg <= ch_reg[33] ? -term_pos : term_pos;
        end else if (cmd.store_sin) begin
            sin_reg <= sh_reg[33] ? -term_pos : term_pos;
        end
    end

    // Cell geometry, in units of 2^-17 m for the offsets.
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic [CW+31:0]      mcs_x;
    logic [RW+31:0]      mcs_y;
    logic [DW-1:0]       dx_next, dy_next;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] pcx_reg, psy_reg, pcy_reg, psx_reg;
    logic signed [PW:0]   fwd, lat;
    logic signed [46:0]   lo_lim, hi_lim, hw_lim;
    logic                 in_window;

    assign mcs_x   = {col_reg, 1'b1} * cell_size_reg;
    assign mcs_y   = {row_reg, 1'b1} * cell_size_reg;
    assign dx_next = {{(DW-33){origin_x_reg[31]}}, origin_x_reg, 1'b0}
                   + {{(DW-CW-32){1'b0}}, mcs_x}
                   - {{(DW-33){pose_x_reg[31]}}, pose_x_reg, 1'b0};
    assign dy_next = {{(DW-33){origin_y_reg[31]}}, origin_y_reg, 1'b0}
                   + {{(DW-RW-32){1'b0}}, mcs_y}
                   - {{(DW-33){pose_y_reg[31]}}, pose_y_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.cell_d) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.cell_m) begin
            pcx_reg <= cos_reg * dx_reg;
            psy_reg <= sin_reg * dy_reg;
            pcy_reg <= cos_reg * dy_reg;
            psx_reg <= sin_reg * dx_reg;
        end
    end

    assign fwd       = pcx_reg + psy_reg;
    assign lat       = pcy_reg - psx_reg;
    assign lo_lim    = {front_min_x_reg, 15'b0};
    assign hi_lim    = {front_max_x_reg, 15'b0};
    assign hw_lim    = {1'b0, half_width_reg, 15'b0};
    assign in_window = (fwd >= lo_lim) && (fwd <= hi_lim)
                    && (lat >= -hw_lim) && (lat <= hw_lim);

    // Raster position and frame totals
    logic [CMPW-1:0] eff_width, col_inc;
    logic [RW:0]     row_inc;
    logic [16:0]     occ_reg, samp_reg;
    logic [7:0]      peak_reg;
    logic            frame_clear;

    assign eff_width = (map_width_reg == 9'd0 || CMPW'(map_width_reg) > CMPW'(MAX_WIDTH))
                     ? CMPW'(MAX_WIDTH) : CMPW'(map_width_reg);
    assign col_inc     = CMPW'(col_reg) + CMPW'(1);
    assign row_inc     = (RW+1)'(row_reg) + (RW+1)'(1);
    assign frame_clear = (cmd.load && !s_tuser) || cmd.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn || frame_clear) begin
            col_reg  <= '0;
            row_reg  <= '0;
            occ_reg  <= '0;
            samp_reg <= '0;
            peak_reg <= '0;
        end else if (cmd.cell_t) begin
            if (in_window) begin
                if (samp_reg < COUNT_LIMIT) begin
                    samp_reg <= samp_reg + 17'd1;
                end
                if (cost_reg > peak_reg) begin
                    peak_reg <= cost_reg;
                end
                if (cost_reg >= cost_threshold_reg && occ_reg < COUNT_LIMIT) begin
                    occ_reg <= occ_reg + 17'd1;
                end
            end
            if (col_inc >= eff_width) begin
                col_reg <= '0;
                row_reg <= (row_inc >= (RW+1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
            end else begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                unavail;

    assign unavail = !kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {4'b0, peak_reg, samp_reg, occ_reg, unavail,
                             unavail || (occ_reg != 17'd0)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.sqrt_done = sqrt_done;
    assign status.div_done  = div_done;
    assign status.root_zero = (root == 32'd0);
    assign status.last_item = last_reg;
    assign status.out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/core/cfws_ctrl.sv @@
`default_nettype none
module cfws_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              in_kind,
    input  logic              m_tready,
    input  cfws_pkg::status_t status,
    output logic              s_tready,
    output cfws_pkg::cmd_t    cmd
);
    import cfws_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_HDG       = 13'b0000000000010,
        ST_SQ_S      = 13'b0000000000100,
        ST_SQ_C      = 13'b0000000001000,
        ST_SQRT_GO   = 13'b0000000010000,
        ST_SQRT_WAIT = 13'b0000000100000,
        ST_DIVC_WAIT = 13'b0000001000000,
        ST_DIVS_GO   = 13'b0000010000000,
        ST_DIVS_WAIT = 13'b0000100000000,
        ST_CELL_D    = 13'b0001000000000,
        ST_CELL_M    = 13'b0010000000000,
        ST_CELL_T    = 13'b0100000000000,
        ST_EMIT      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = in_kind ? ST_CELL_D : ST_HDG;
                end
            end
            ST_HDG: begin
                cmd.hdg    = 1'b1;
                state_next = ST_SQ_S;
            end
            ST_SQ_S: begin
                cmd.sq_s   = 1'b1;
                state_next = ST_SQ_C;
            end
            ST_SQ_C: begin
                cmd.sq_c   = 1'b1;
                state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (status.sqrt_done) begin
                    if (status.root_zero) begin
                        // Both heading terms zero: face along the x axis.
                        cmd.heading_unit = 1'b1;
                        state_next       = status.last_item ? ST_EMIT : ST_IDLE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVC_WAIT;
                    end
                end
            end
            ST_DIVC_WAIT: begin
                if (status.div_done) begin
                    cmd.store_cos = 1'b1;
                    state_next    = ST_DIVS_GO;
                end
            end
            ST_DIVS_GO: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_sin = 1'b1;
                state_next      = ST_DIVS_WAIT;
            end
            ST_DIVS_WAIT: begin
                if (status.div_done) begin
                    cmd.store_sin = 1'b1;
                    state_next    = status.last_item ? ST_EMIT : ST_IDLE;
                end
            end
            ST_CELL_D: begin
                cmd.cell_d = 1'b1;
                state_next = ST_CELL_M;
            end
            ST_CELL_M: begin
                cmd.cell_m = 1'b1;
                state_next = ST_CELL_T;
            end
            ST_CELL_T: begin
                cmd.cell_t = 1'b1;
                state_next = status.last_item ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!status.out_valid || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
